@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define DCG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define DCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DCG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DCG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/dcg_pkg.sv @@
`default_nettype none

package dcg_pkg;

   // field widths
   localparam int COUNT_W   = 22;
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int WEEKDAY_W = 3;

   // pipeline stages
   localparam int STAGES    = 6;
   localparam int STG_PREP  = 0;
   localparam int STG_ERA   = 1;
   localparam int STG_CENT  = 2;
   localparam int STG_QUAD  = 3;
   localparam int STG_YEAR  = 4;
   localparam int STG_DATE  = 5;

   // calendar constants, years counted from march 1st
   localparam int unsigned LAST_COUNT   = 2921939;
   localparam int unsigned ERA_DAYS     = 146097;
   localparam int unsigned CENTURY_DAYS = 36524;
   localparam int unsigned QUAD_DAYS    = 1461;
   localparam int unsigned YEAR_DAYS    = 365;
   // 1600-03-01 lies this many days before 2000-01-01
   localparam int unsigned EPOCH_SHIFT  = ERA_DAYS - 60;
   localparam int unsigned BASE_YEAR    = 1600;
   localparam int unsigned ERA_YEARS    = 400;
   localparam int unsigned CENT_YEARS   = 100;
   localparam int MAX_ERA  = 20;
   localparam int MAX_CENT = 3;
   localparam int MAX_QUAD = 24;
   localparam int MAX_YEAR = 3;
   localparam int MONTHS   = 12;
   localparam int JAN_SLOT = 10;

   typedef logic [STAGES-1:0] stage_en_type;

   // values that ride along unchanged
   typedef struct packed {
      logic                 range_error;
      logic [WEEKDAY_W-1:0] weekday;
      logic [4:0]           era;
   } date_tag_type;

   typedef struct packed {
      date_tag_type tag;
      logic [17:0]  doe;
   } era_split_type;

   typedef struct packed {
      date_tag_type tag;
      logic [8:0]   yoe;
      logic [8:0]   doy;
   } year_split_type;

   typedef struct packed {
      logic [YEAR_W-1:0]    year_number;
      logic [MONTH_W-1:0]   month_number;
      logic [DAY_W-1:0]     day_of_month;
      logic [WEEKDAY_W-1:0] weekday;
      logic                 range_error;
   } date_result_type;

   // first day of each month within a march-based year
   function automatic logic [8:0] month_start(input logic [3:0] slot);
      logic [8:0] start;
      case (slot)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dcg_channel_if.sv @@
`default_nettype none

// request channel: one day count
interface dcg_req_if import dcg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] day_count;

   modport source (output valid, output day_count, input ready);
   modport sink   (input valid, input day_count, output ready);
endinterface

// response channel: one calendar date
interface dcg_rsp_if import dcg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [YEAR_W-1:0]    year_number;
   logic [MONTH_W-1:0]   month_number;
   logic [DAY_W-1:0]     day_of_month;
   logic [WEEKDAY_W-1:0] weekday;
   logic                 range_error;

   modport source (output valid, output year_number, output month_number,
                   output day_of_month, output weekday, output range_error,
                   input ready);
   modport sink   (input valid, input year_number, input month_number,
                   input day_of_month, input weekday, input range_error,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/day_count_to_gregorian_date_unit.sv @@
// six register stages lie between an accepted request and its response
// throughput: one request per cycle; ready falls only when the pipeline is full
//   and the response is not taken
// reset: synchronous, active high; clears all stage valid bits, no clearing pass
`default_nettype none

`include "assert_macros.svh"

module day_count_to_gregorian_date_unit import dcg_pkg::*; (
   input logic       clock,
   input logic       reset,
   dcg_req_if.sink   req_if,
   dcg_rsp_if.source rsp_if
);

   logic [STAGES-1:0] valid_in, valid_ff;
   stage_en_type      stage_en;
   era_split_type     era_split;
   year_split_type    year_split;
   date_result_type   date_result;

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_if.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = stage_en[0] ? req_if.valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // datapath
   dcg_era_split u_era_split (
      .clock     (clock),
      .stage_en  (stage_en),
      .day_count (req_if.day_count),
      .era_out   (era_split)
   );

   dcg_year_split u_year_split (
      .clock    (clock),
      .stage_en (stage_en),
      .era_in   (era_split),
      .year_out (year_split)
   );

   dcg_month_split u_month_split (
      .clock    (clock),
      .stage_en (stage_en),
      .year_in  (year_split),
      .date_out (date_result)
   );

   // channel hookup
   assign req_if.ready        = stage_en[0];
   assign rsp_if.valid        = valid_ff[STAGES-1];
   assign rsp_if.year_number  = date_result.year_number;
   assign rsp_if.month_number = date_result.month_number;
   assign rsp_if.day_of_month = date_result.day_of_month;
   assign rsp_if.weekday      = date_result.weekday;
   assign rsp_if.range_error  = date_result.range_error;

   // checks
   `DCG_ASSERT_IMPL(a_range_zeroes, clock, reset, rsp_if.valid && rsp_if.range_error, rsp_if.year_number == '0 && rsp_if.month_number == '0 && rsp_if.day_of_month == '0)
   `DCG_ASSERT_IMPL(a_date_legal, clock, reset, rsp_if.valid && !rsp_if.range_error, rsp_if.month_number >= 4'd1 && rsp_if.month_number <= 4'd12 && rsp_if.day_of_month >= 5'd1 && rsp_if.year_number >= 14'd2000 && rsp_if.weekday <= 3'd6)
   `DCG_ASSERT_IMPL(a_full_blocks, clock, reset, (&valid_ff) && !rsp_if.ready, !req_if.ready)
   `DCG_ASSERT_NEXT(a_accept_enters, clock, reset, req_if.valid && req_if.ready, valid_ff[0])

endmodule

`default_nettype wire

@@ rtl/dcg_era_split.sv @@
`default_nettype none

module dcg_era_split import dcg_pkg::*; (
   input  logic               clock,
   input  stage_en_type       stage_en,
   input  logic [COUNT_W-1:0] day_count,
   output era_split_type      era_out
);

   logic [22:0]          shifted_in, shifted_ff;
   logic [WEEKDAY_W-1:0] weekday_in, weekday_ff;
   logic                 range_in, range_ff;
   logic [23:0]          padded;
   logic [5:0]           fold1;
   logic [3:0]           fold2;
   logic [2:0]           fold3;
   logic [4:0]           era_sel;
   logic [22:0]          era_base;
   era_split_type        era_in, era_ff;

   // weekday by summing octal digits, since 8 is 1 mod 7
   always_comb begin
      padded = {2'b00, day_count};
      fold1  = '0;
      for (int g = 0; g < 8; g++) begin
         fold1 = fold1 + 6'(padded[3*g +: 3]);
      end
      fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
      fold3 = {2'b00, fold2[3]} + fold2[2:0];
      weekday_in = (fold3 == 3'd7) ? 3'd0 : fold3;
   end

   // move origin to 1600-03-01 and flag counts past the last date
   assign shifted_in = 23'(day_count) + 23'(EPOCH_SHIFT);
   assign range_in   = day_count > COUNT_W'(LAST_COUNT);

   // whole 400-year eras by parallel threshold compares
   always_comb begin
      era_sel  = '0;
      era_base = '0;
      for (int k = 1; k <= MAX_ERA; k++) begin
         if (shifted_ff >= 23'(k * ERA_DAYS)) begin
            era_sel  = 5'(k);
            era_base = 23'(k * ERA_DAYS);
         end
      end
      era_in.tag.range_error = range_ff;
      era_in.tag.weekday     = weekday_ff;
      era_in.tag.era         = era_sel;
      era_in.doe             = 18'(shifted_ff - era_base);
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (stage_en[STG_PREP]) begin
         shifted_ff <= shifted_in;
         weekday_ff <= weekday_in;
         range_ff   <= range_in;
      end
      if (stage_en[STG_ERA]) begin
         era_ff <= era_in;
      end
   end

   assign era_out = era_ff;

endmodule

`default_nettype wire

@@ rtl/dcg_year_split.sv @@
`default_nettype none

module dcg_year_split import dcg_pkg::*; (
   input  logic           clock,
   input  stage_en_type   stage_en,
   input  era_split_type  era_in,
   output year_split_type year_out
);

   date_tag_type   cent_tag_ff, quad_tag_ff;
   logic [1:0]     cent_in, cent_ff, quad_cent_ff;
   logic [15:0]    doc_in, doc_ff;
   logic [16:0]    cent_base;
   logic [4:0]     quad_in, quad_ff;
   logic [10:0]    dob_in, dob_ff;
   logic [15:0]    quad_base;
   logic [1:0]     yr_sel;
   logic [10:0]    yr_base;
   year_split_type year_in, year_ff;

   // centuries within the era, last one is a day longer
   always_comb begin
      cent_in   = '0;
      cent_base = '0;
      for (int k = 1; k <= MAX_CENT; k++) begin
         if (era_in.doe >= 18'(k * CENTURY_DAYS)) begin
            cent_in   = 2'(k);
            cent_base = 17'(k * CENTURY_DAYS);
         end
      end
      doc_in = 16'(era_in.doe - 18'(cent_base));
   end

   // four-year blocks within the century
   always_comb begin
      quad_in   = '0;
      quad_base = '0;
      for (int k = 1; k <= MAX_QUAD; k++) begin
         if (doc_ff >= 16'(k * QUAD_DAYS)) begin
            quad_in   = 5'(k);
            quad_base = 16'(k * QUAD_DAYS);
         end
      end
      dob_in = 11'(doc_ff - quad_base);
   end

   // years within the block, and year of era
   always_comb begin
      yr_sel  = '0;
      yr_base = '0;
      for (int k = 1; k <= MAX_YEAR; k++) begin
         if (dob_ff >= 11'(k * YEAR_DAYS)) begin
            yr_sel  = 2'(k);
            yr_base = 11'(k * YEAR_DAYS);
         end
      end
      year_in.tag = quad_tag_ff;
      year_in.yoe = 9'(quad_cent_ff) * 9'(CENT_YEARS) + 9'({quad_ff, 2'b00})
                    + 9'(yr_sel);
      year_in.doy = 9'(dob_ff - yr_base);
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (stage_en[STG_CENT]) begin
         cent_tag_ff <= era_in.tag;
         cent_ff     <= cent_in;
         doc_ff      <= doc_in;
      end
      if (stage_en[STG_QUAD]) begin
         quad_tag_ff  <= cent_tag_ff;
         quad_cent_ff <= cent_ff;
         quad_ff      <= quad_in;
         dob_ff       <= dob_in;
      end
      if (stage_en[STG_YEAR]) begin
         year_ff <= year_in;
      end
   end

   assign year_out = year_ff;

endmodule

`default_nettype wire

@@ rtl/dcg_month_split.sv @@
`default_nettype none

module dcg_month_split import dcg_pkg::*; (
   input  logic            clock,
   input  stage_en_type    stage_en,
   input  year_split_type  year_in,
   output date_result_type date_out
);

   logic [3:0]      slot;
   logic [8:0]      slot_start;
   logic            jan_feb;
   date_result_type date_in, date_ff;

   // month slot in the march-based year
   always_comb begin
      slot       = '0;
      slot_start = '0;
      for (int k = 1; k < MONTHS; k++) begin
         if (year_in.doy >= month_start(4'(k))) begin
            slot       = 4'(k);
            slot_start = month_start(4'(k));
         end
      end
   end

   // calendar fields, zeroed past the last date
   always_comb begin
      jan_feb = slot >= 4'(JAN_SLOT);
      date_in.weekday     = year_in.tag.weekday;
      date_in.range_error = year_in.tag.range_error;
      if (year_in.tag.range_error) begin
         date_in.year_number  = '0;
         date_in.month_number = '0;
         date_in.day_of_month = '0;
      end else begin
         date_in.year_number  = YEAR_W'(BASE_YEAR)
                                + YEAR_W'(year_in.tag.era) * YEAR_W'(ERA_YEARS)
                                + YEAR_W'(year_in.yoe) + YEAR_W'(jan_feb);
         date_in.month_number = jan_feb ? slot - 4'(JAN_SLOT - 1) : slot + 4'd3;
         date_in.day_of_month = DAY_W'(year_in.doy - slot_start + 9'd1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (stage_en[STG_DATE]) begin
         date_ff <= date_in;
      end
   end

   assign date_out = date_ff;

endmodule

`default_nettype wire
